FILE: src/fbdq_pkg.sv
`default_nettype none
package fbdq_pkg;

    // Lane count and accumulator width.
    localparam int LANES     = 4;
    localparam int ACC_WIDTH = 48;

    // Field widths.
    localparam int ACT_WIDTH   = 16;
    localparam int SCALE_WIDTH = 16;
    localparam int CODE_WIDTH  = 4;
    // The dequantized weight spans the integer mode's range of (c - 8) * s.
    localparam int W_WIDTH     = 20;
    localparam int P_WIDTH     = W_WIDTH + ACT_WIDTH;

    // Packed widths of the stream payloads.
    localparam int S_TDATA_WIDTH = ACT_WIDTH + 16 + LANES * SCALE_WIDTH;
    localparam int M_TDATA_WIDTH = LANES * ACC_WIDTH;

    // Quantization modes held in the configuration register.
    localparam logic MODE_NF  = 1'b0;
    localparam logic MODE_INT = 1'b1;

    // Sequencer states: one item moves through weight, product and sum steps.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WGT,
        ST_MUL,
        ST_ACC
    } t_state;

    // Per-step strobes that the sequencer sends to every lane.
    typedef struct packed {
        logic load_w;
        logic load_p;
        logic acc_en;
        logic acc_clr;
    } t_lane_ctrl;

    // NormalFloat code table in Q1.15, with +1.0 saturated to the largest value.
    function automatic logic signed [15:0] nf_value(input logic [CODE_WIDTH-1:0] code);
        logic signed [15:0] v;
        unique case (code)
            4'd0:    v = -16'sd32768;
            4'd1:    v = -16'sd22813;
            4'd2:    v = -16'sd17206;
            4'd3:    v = -16'sd12941;
            4'd4:    v = -16'sd9321;
            4'd5:    v = -16'sd6055;
            4'd6:    v = -16'sd2984;
            4'd7:    v = 16'sd0;
            4'd8:    v = 16'sd2608;
            4'd9:    v = 16'sd5273;
            4'd10:   v = 16'sd8065;
            4'd11:   v = 16'sd11073;
            4'd12:   v = 16'sd14441;
            4'd13:   v = 16'sd18436;
            4'd14:   v = 16'sd23690;
            default: v = 16'sd32767;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/fbdq_lane.sv
`default_nettype none
module fbdq_lane (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_mode,
    input  wire logic [fbdq_pkg::CODE_WIDTH-1:0]            i_code,
    input  wire logic signed [fbdq_pkg::SCALE_WIDTH-1:0]    i_scale,
    input  wire logic signed [fbdq_pkg::ACT_WIDTH-1:0]      i_act,
    input  wire fbdq_pkg::t_lane_ctrl                       i_ctrl,
    output logic signed [fbdq_pkg::ACC_WIDTH-1:0]           o_sum
);

    localparam int DQ_WIDTH = 16 + fbdq_pkg::SCALE_WIDTH;
    localparam int SUM_WIDTH = fbdq_pkg::ACC_WIDTH + 1;

    logic signed [15:0]                       w_op;
    logic signed [DQ_WIDTH-1:0]               dq_prod;
    logic signed [fbdq_pkg::W_WIDTH-1:0]      n_w;
    logic signed [fbdq_pkg::W_WIDTH-1:0]      r_w;
    logic signed [fbdq_pkg::P_WIDTH-1:0]      r_prod;
    logic signed [fbdq_pkg::ACC_WIDTH-1:0]    r_acc;
    logic signed [SUM_WIDTH-1:0]              sum_ext;

    // One shared multiplier: the table value or the code minus eight, times the scale.
    // The code minus eight is the code with its top bit inverted, read as signed.
    always_comb begin
        if (i_mode == fbdq_pkg::MODE_INT) begin
            w_op = {{12{~i_code[3]}}, ~i_code[3], i_code[2:0]};
        end else begin
            w_op = fbdq_pkg::nf_value(i_code);
        end
        dq_prod = w_op * i_scale;
        // The table product is shifted right by 15 with floor rounding.
        if (i_mode == fbdq_pkg::MODE_INT) begin
            n_w = dq_prod[fbdq_pkg::W_WIDTH-1:0];
        end else begin
            n_w = {{(fbdq_pkg::W_WIDTH + 15 - DQ_WIDTH){dq_prod[DQ_WIDTH-1]}},
                   dq_prod[DQ_WIDTH-1:15]};
        end
    end

    // Weight and product registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_w) begin
            r_w <= n_w;
        end
        if (i_ctrl.load_p) begin
            r_prod <= r_w * i_act;
        end
    end

    // Saturating add: one guard bit shows an overflow of the accumulator range.
    always_comb begin
        sum_ext = {r_acc[fbdq_pkg::ACC_WIDTH-1], r_acc}
                + {{(SUM_WIDTH - fbdq_pkg::P_WIDTH){r_prod[fbdq_pkg::P_WIDTH-1]}}, r_prod};
        if (sum_ext[SUM_WIDTH-1] != sum_ext[SUM_WIDTH-2]) begin
            o_sum = {sum_ext[SUM_WIDTH-1], {(fbdq_pkg::ACC_WIDTH-1){~sum_ext[SUM_WIDTH-1]}}};
        end else begin
            o_sum = sum_ext[fbdq_pkg::ACC_WIDTH-1:0];
        end
    end

    // Accumulator: takes the saturated sum, or clears after the last item of a dot product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            if (i_ctrl.acc_clr) begin
                r_acc <= '0;
            end else begin
                r_acc <= o_sum;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/four_bit_dequant_mac_lanes_core.sv
// Results: a result appears on the master side once the item marked last has passed the
// weight multiplier, the product multiplier and the accumulator step in turn; the
// accumulator step of a last item waits for a free output slot.
// Items: the sequencer walks each item through those three steps before it takes the
// next one.
// Reset: synchronous, active low; clears the mode register, the accumulators and the output valid flag.
`default_nettype none
module four_bit_dequant_mac_lanes_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration: bit 0 is quant_mode.
    input  wire logic                                   i_cfg_we,
    input  wire logic                                   i_cfg_wdata,
    // Input stream.
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // Fields from bit 0: activation, packed_pair, scale_lane0 .. scale_lane3.
    input  wire logic [fbdq_pkg::S_TDATA_WIDTH-1:0]     i_s_tdata,
    // last_of_dot.
    input  wire logic                                   i_s_tlast,
    // Output stream.
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // Fields from bit 0: sum_lane0 .. sum_lane3.
    output logic [fbdq_pkg::M_TDATA_WIDTH-1:0]          o_m_tdata
);

    localparam int PAIR_LSB  = fbdq_pkg::ACT_WIDTH;
    localparam int SCALE_LSB = fbdq_pkg::ACT_WIDTH + 16;

    fbdq_pkg::t_state      r_state;
    fbdq_pkg::t_state      n_state;
    fbdq_pkg::t_lane_ctrl  lane_ctrl;
    logic                  r_mode;
    logic                  r_last;
    logic                  out_free;
    logic                  out_load;
    logic                  s_fire;
    logic signed [fbdq_pkg::ACT_WIDTH-1:0]  r_act;
    logic [15:0]                            r_pair;
    logic [fbdq_pkg::LANES*fbdq_pkg::SCALE_WIDTH-1:0] r_scales;
    logic [fbdq_pkg::M_TDATA_WIDTH-1:0]     lane_sums;
    logic                                   r_out_valid;
    logic [fbdq_pkg::M_TDATA_WIDTH-1:0]     r_out_data;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fbdq_pkg::MODE_NF;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign s_fire   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // Input holding registers, loaded on a transfer.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_act    <= i_s_tdata[fbdq_pkg::ACT_WIDTH-1:0];
            r_pair   <= i_s_tdata[PAIR_LSB +: 16];
            r_scales <= i_s_tdata[SCALE_LSB +: fbdq_pkg::LANES*fbdq_pkg::SCALE_WIDTH];
            r_last   <= i_s_tlast;
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and lane strobes. The sum step of a last item waits for a free output slot.
    always_comb begin
        n_state    = r_state;
        lane_ctrl  = '0;
        o_s_tready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            fbdq_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = fbdq_pkg::ST_WGT;
                end
            end
            fbdq_pkg::ST_WGT: begin
                lane_ctrl.load_w = 1'b1;
                n_state = fbdq_pkg::ST_MUL;
            end
            fbdq_pkg::ST_MUL: begin
                lane_ctrl.load_p = 1'b1;
                n_state = fbdq_pkg::ST_ACC;
            end
            fbdq_pkg::ST_ACC: begin
                if (!r_last || out_free) begin
                    lane_ctrl.acc_en  = 1'b1;
                    lane_ctrl.acc_clr = r_last;
                    out_load = r_last;
                    n_state  = fbdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fbdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Lanes work side by side on their own code and scale.
    for (genvar g = 0; g < fbdq_pkg::LANES; g++) begin : g_lane
        fbdq_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_mode  (r_mode),
            .i_code  (r_pair[g*fbdq_pkg::CODE_WIDTH +: fbdq_pkg::CODE_WIDTH]),
            .i_scale (r_scales[g*fbdq_pkg::SCALE_WIDTH +: fbdq_pkg::SCALE_WIDTH]),
            .i_act   (r_act),
            .i_ctrl  (lane_ctrl),
            .o_sum   (lane_sums[g*fbdq_pkg::ACC_WIDTH +: fbdq_pkg::ACC_WIDTH])
        );
    end

    // Output register merges the lane sums into one result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= lane_sums;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // An accepted item keeps the input side closed for its three processing steps.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !o_s_tready ##1 !o_s_tready ##1 !o_s_tready)
        else $error("input accepted while an item was still in work");

    // A new result comes only from the sum step of an item marked last.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == fbdq_pkg::ST_ACC && r_last))
        else $error("result raised without a last item");

    // A result that waits is not overwritten by the next dot product.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("pending result changed");

endmodule
`default_nettype wire
